>>> src/lie_pkg.sv
// Package for the line input editor: character codes, the command word that
// passes from the front part to the back part, and the result word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lie_pkg;

	localparam int BUFFER_DEPTH_DEF = 256;
	localparam int CMD_DEPTH_DEF = 4;

	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 9'd256;

	localparam logic [7:0] CH_EOT = 8'd4;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_SP = 8'd32;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       done_res;
		logic [8:0] length;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       erase;
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       done_res;
		logic [8:0] length;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

>>> src/lie_front.sv
// Front part of the line input editor: classifies each received byte, keeps the line position
// and builds one command word per byte, none for a delete on an empty line. Uses lie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lie_front
	import lie_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [COUNT_W-1:0] max_count,
	output      logic               cmd_push,
	output      cmd_t               cmd
);

	localparam int CAP = (BUFFER_DEPTH < 511) ? BUFFER_DEPTH : 511;
	localparam int POS_W = $clog2(CAP);
	localparam logic [9:0] CLAMP = 10'(CAP);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic [9:0] pos_ext;
	logic [9:0] pos_inc;
	logic [9:0] eff_count;
	logic [9:0] req_count;

	assign pos_ext = 10'(pos_q);
	assign pos_inc = pos_ext + 10'd1;
	assign req_count = (max_count == '0) ? 10'd1 : 10'(max_count);
	assign eff_count = (req_count > CLAMP) ? CLAMP : req_count;

	always_comb begin
		cmd = '0;
		cmd_push = accept;
		pos_d = pos_q;
		if (rx_byte == CH_EOT) begin
			cmd.done_res = 1'b1;
			cmd.length = 9'(pos_ext);
			pos_d = '0;
		end else if (rx_byte == CH_DEL) begin
			if (pos_q == '0) begin
				cmd_push = 1'b0;
			end else begin
				pos_d = pos_q - POS_W'(1);
				cmd.erase = 1'b1;
				cmd.echo_valid = 1'b1;
				cmd.echo_byte = CH_BS;
				cmd.store_valid = 1'b1;
				cmd.store_index = 8'(pos_q - POS_W'(1));
			end
		end else if (rx_byte == CH_LF || rx_byte == CH_CR) begin
			cmd.echo_valid = 1'b1;
			cmd.echo_byte = CH_LF;
			cmd.store_valid = 1'b1;
			cmd.store_index = 8'(pos_q);
			cmd.store_byte = rx_byte;
			cmd.done_res = 1'b1;
			cmd.length = 9'(pos_inc);
			pos_d = '0;
		end else begin
			cmd.echo_valid = 1'b1;
			cmd.echo_byte = rx_byte;
			cmd.store_valid = 1'b1;
			cmd.store_index = 8'(pos_q);
			cmd.store_byte = rx_byte;
			if (pos_inc >= eff_count) begin
				cmd.done_res = 1'b1;
				cmd.length = 9'(pos_inc);
				pos_d = '0;
			end else begin
				pos_d = POS_W'(pos_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
		end
	end

endmodule

`default_nettype wire

>>> src/lie_cmd_fifo.sv
// Short command queue between the front and back parts of the line input
// editor; registers, one word in/out per cycle unless full/empty. Uses lie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lie_cmd_fifo
	import lie_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output fifo_stat_t stat
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && !stat.empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/lie_back.sv
// Back part of the line input editor: expands each command word into its
// result words and holds the oldest one in an output register. Uses lie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lie_back
	import lie_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_avail,
	output      logic cmd_pop,
	input  wire logic pop,
	output      logic out_valid,
	output result_t   out
);

	logic [1:0] step_q;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res;
	logic       slot_free;
	logic       load;
	logic       final_word;

	assign slot_free = !out_valid_q || pop;
	assign load = slot_free && cmd_avail;
	assign final_word = !cmd.erase || (step_q == 2'd2);
	assign cmd_pop = load && final_word;

	always_comb begin
		res.echo_valid = cmd.echo_valid;
		res.echo_byte = cmd.echo_byte;
		res.store_valid = cmd.store_valid;
		res.store_index = cmd.store_index;
		res.store_byte = cmd.store_byte;
		res.done_res = cmd.done_res;
		res.length = cmd.length;
		res.last = final_word;
		if (cmd.erase && step_q != 2'd0) begin
			res.store_valid = 1'b0;
			res.store_index = '0;
			res.store_byte = '0;
			res.echo_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q <= final_word ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out = out_q;

endmodule

`default_nettype wire

>>> src/line_input_editor_top.sv
// Top level of the line input editor: configuration register, front part,
// command queue and back part. Uses lie_pkg, lie_front, lie_cmd_fifo, lie_back.
//
// Usage: received console bytes go in through push/full; a byte is taken at a
// clock edge with push high and full low. Result words come out through
// empty/pop; the oldest word is on the result ports while empty is low and is
// taken at an edge with pop high. Each byte gives one word, a delete (127) on a
// nonempty line gives three (backspace, space, backspace echo), and a delete
// on an empty line gives none. The last port marks the final word of a byte.
// max_count is written at an edge with max_count_we high; the user is to write it
// only while the block idles, which the block does not enforce. When nothing
// waits, a byte's command enters the queue at the edge that takes the byte, and
// its word is then loaded into the output register. One byte per cycle goes in
// while full is low, one word per cycle out while pop is high; an erase command
// stays at the head of the queue until all three of its words are loaded. The
// command queue holds CMD_DEPTH commands; full rises when it fills while the
// receiver stalls, and the held word stays unchanged until popped. Reset clears
// the line position, the queue and the output, and sets max_count to 256.
`timescale 1ns / 1ps
`default_nettype none

module line_input_editor_top
	import lie_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output      logic               full,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               max_count_we,
	input  wire logic [COUNT_W-1:0] max_count,
	output      logic               empty,
	input  wire logic               pop,
	output      logic               echo_valid,
	output      logic [7:0]         echo_byte,
	output      logic               store_valid,
	output      logic [7:0]         store_index,
	output      logic [7:0]         store_byte,
	output      logic               done_res,
	output      logic [8:0]         length,
	output      logic               last
);

	logic [COUNT_W-1:0] max_count_q;
	logic       accept;
	logic       cmd_push;
	cmd_t       cmd_in;
	cmd_t       cmd_head;
	fifo_stat_t fifo_stat;
	logic       cmd_pop;
	logic       out_valid;
	result_t    out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RESET;
		end else if (max_count_we) begin
			max_count_q <= max_count;
		end
	end

	assign full = fifo_stat.full;
	assign accept = push && !fifo_stat.full;

	lie_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.max_count(max_count_q),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	lie_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data(cmd_in),
		.rd_en(cmd_pop),
		.rd_data(cmd_head),
		.stat(fifo_stat)
	);

	lie_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_head),
		.cmd_avail(!fifo_stat.empty),
		.cmd_pop(cmd_pop),
		.pop(pop),
		.out_valid(out_valid),
		.out(out)
	);

	assign empty = !out_valid;
	assign echo_valid = out.echo_valid;
	assign echo_byte = out.echo_byte;
	assign store_valid = out.store_valid;
	assign store_index = out.store_index;
	assign store_byte = out.store_byte;
	assign done_res = out.done_res;
	assign length = out.length;
	assign last = out.last;

	a_nonlast_is_erase_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (echo_valid && (echo_byte == CH_BS || echo_byte == CH_SP)))
		else $error("non-final word is not an erase echo");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> last)
		else $error("line completion on a non-final word");

	a_byte_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && rx_byte != CH_DEL) |=> ##1 !empty)
		else $error("accepted byte produced no result word");

endmodule

`default_nettype wire

>>> dv/line_edit_checker.sv
// Checker for the line input editor: watches the byte, configuration and result
// channels, predicts every result word and compares it with what the block pops.
// Depends on lie_pkg for the character codes and the result word layout.
`timescale 1ns / 1ps

module line_edit_checker
	import lie_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               max_count_we,
	input  logic [COUNT_W-1:0] max_count,
	input  logic               empty,
	input  logic               pop,
	input  logic               echo_valid,
	input  logic [7:0]         echo_byte,
	input  logic               store_valid,
	input  logic [7:0]         store_index,
	input  logic [7:0]         store_byte,
	input  logic               done_res,
	input  logic [8:0]         length,
	input  logic               last,
	output int                 pending,
	output int                 fail_count
);

	result_t expected_words[$];
	int line_pos = 0;
	logic [COUNT_W-1:0] count_reg = MAX_COUNT_RESET;
	int errors = 0;

	function automatic string word_text(input result_t w);
		return $sformatf("echo=%0d/%02h store=%0d/%0d/%02h done=%0d len=%0d last=%0d",
			w.echo_valid, w.echo_byte, w.store_valid, w.store_index, w.store_byte,
			w.done_res, w.length, w.last);
	endfunction

	function automatic void predict_line_edit(input logic [7:0] b);
		result_t w;
		int limit;
		w = '0;
		limit = (count_reg == 0) ? 1 :
			(count_reg > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF : int'(count_reg);
		if (b == CH_EOT) begin
			w.done_res = 1'b1;
			w.length = 9'(line_pos);
			w.last = 1'b1;
			expected_words.push_back(w);
			line_pos = 0;
		end else if (b == CH_DEL) begin
			if (line_pos != 0) begin
				line_pos--;
				w.echo_valid = 1'b1;
				w.echo_byte = CH_BS;
				w.store_valid = 1'b1;
				w.store_index = 8'(line_pos);
				expected_words.push_back(w);
				w = '0;
				w.echo_valid = 1'b1;
				w.echo_byte = CH_SP;
				expected_words.push_back(w);
				w.echo_byte = CH_BS;
				w.last = 1'b1;
				expected_words.push_back(w);
			end
		end else if (b == CH_LF || b == CH_CR) begin
			w.echo_valid = 1'b1;
			w.echo_byte = CH_LF;
			w.store_valid = 1'b1;
			w.store_index = 8'(line_pos);
			w.store_byte = b;
			w.done_res = 1'b1;
			w.length = 9'(line_pos + 1);
			w.last = 1'b1;
			expected_words.push_back(w);
			line_pos = 0;
		end else begin
			w.echo_valid = 1'b1;
			w.echo_byte = b;
			w.store_valid = 1'b1;
			w.store_index = 8'(line_pos);
			w.store_byte = b;
			w.last = 1'b1;
			line_pos++;
			if (line_pos >= limit) begin
				w.done_res = 1'b1;
				w.length = 9'(line_pos);
				line_pos = 0;
			end
			expected_words.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			line_pos = 0;
			count_reg = MAX_COUNT_RESET;
			expected_words.delete();
		end else begin
			if (max_count_we)
				count_reg = max_count;
			if (push && !full)
				predict_line_edit(rx_byte);
			if (pop && !empty) begin
				got = {echo_valid, echo_byte, store_valid, store_index, store_byte,
					done_res, length, last};
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected word %s", $time, word_text(got));
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got != want) begin
						if (errors < 10)
							$display("%0t: word mismatch, expected %s, actual %s",
								$time, word_text(want), word_text(got));
						errors++;
					end
				end
			end
		end
		pending <= expected_words.size();
		fail_count <= errors;
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for the line input editor: clock, reset, byte and configuration
// stimulus with random idling, and the verdict.
// Depends on lie_pkg, line_input_editor_top and line_edit_checker.
`timescale 1ns / 1ps

module tb_top;
	import lie_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [COUNT_W-1:0] PHASE_COUNTS [9] = '{9'd3, 9'd1, 9'd0, 9'd2, 9'd16,
		9'd511, 9'd255, 9'd257, 9'd6};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic max_count_we = 1'b0;
	logic [COUNT_W-1:0] max_count = '0;
	logic pop = 1'b0;
	logic full, empty;
	logic echo_valid, store_valid, done_res, last;
	logic [7:0] echo_byte, store_index, store_byte;
	logic [8:0] length;
	int pending;
	int fail_count;
	int cycles = 0;
	int sent = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	line_input_editor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.max_count_we(max_count_we),
		.max_count(max_count),
		.empty(empty),
		.pop(pop),
		.echo_valid(echo_valid),
		.echo_byte(echo_byte),
		.store_valid(store_valid),
		.store_index(store_index),
		.store_byte(store_byte),
		.done_res(done_res),
		.length(length),
		.last(last)
	);

	line_edit_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.max_count_we(max_count_we),
		.max_count(max_count),
		.empty(empty),
		.pop(pop),
		.echo_valid(echo_valid),
		.echo_byte(echo_byte),
		.store_valid(store_valid),
		.store_index(store_index),
		.store_byte(store_byte),
		.done_res(done_res),
		.length(length),
		.last(last),
		.pending(pending),
		.fail_count(fail_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("line_input_editor_top verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm) begin
			pop <= 1'b1;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			pop <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] v);
		drain();
		max_count_we <= 1'b1;
		max_count <= v;
		@(posedge clk);
		max_count_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b inside {CH_EOT, CH_DEL, CH_LF, CH_CR});
		return b;
	endfunction

	// A line is mostly ordinary bytes with some erasures and a little noise,
	// closed by a terminator or left to end on the count.
	task automatic send_line(input logic [COUNT_W-1:0] v);
		int cap;
		int n;
		int r;
		cap = (v == 0) ? 2 : (v > 20) ? 21 : int'(v) + 1;
		n = $urandom_range(0, cap);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				send_byte(CH_DEL);
			else if (r < 14)
				send_byte(8'($urandom_range(0, 255)));
			else
				send_byte(pick_plain());
		end
		case ($urandom_range(0, 3))
			0: send_byte(CH_LF);
			1: send_byte(CH_CR);
			2: send_byte(CH_EOT);
			default: ;
		endcase
	endtask

	initial begin
		int base;
		logic [COUNT_W-1:0] v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(CH_EOT);
		send_byte(CH_DEL);
		send_byte(8'h61);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_DEL);
		send_byte(CH_DEL);
		send_byte(CH_CR);
		send_byte(8'h7E);
		send_byte(CH_LF);
		send_byte(8'h03);
		send_byte(8'h05);
		send_byte(CH_EOT);
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(8'h63);
		// Lowering the count below the position ends the line on the next byte.
		set_count(9'd2);
		send_byte(8'h64);
		set_count(9'd1);
		send_byte(8'h41);
		send_byte(CH_DEL);
		send_byte(CH_LF);
		set_count(9'd0);
		send_byte(8'h42);
		send_byte(CH_EOT);

		for (int i = 0; i < 9; i++) begin
			v = (i == 8) ? 9'($urandom_range(1, 40)) : PHASE_COUNTS[i];
			set_count(v);
			if (i == 8)
				calm <= 1'b1;
			if (v == 9'd511)
				repeat (256) send_byte(pick_plain());
			base = sent;
			while (sent - base < 20)
				send_line(v);
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("line_input_editor_top verification clean");
		else
			$display("line_input_editor_top verification failed");
		$finish;
	end

endmodule
